/* sv/cpq_pkg.sv */
// shared types, constants and helpers for the two-priority packet queue
`timescale 1ns / 1ps
package cpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_PAYLOAD = 62;

  // each priority owns a ring of one slot more than its depth
  localparam int RING      = QUEUE_DEPTH + 1;
  localparam int SLOTS     = 2 * RING;
  localparam int PTR_W     = $clog2(RING);
  localparam int FILL_W    = $clog2(RING);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int PAY_DEPTH = SLOTS * MAX_PAYLOAD;
  localparam int PAY_AW    = $clog2(PAY_DEPTH);
  localparam int LEN_W     = 6;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_HEADER   = 2'd0,
    OP_PAYLOAD  = 2'd1,
    OP_CHECKSUM = 2'd2,
    OP_DEQUEUE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_STATUS   = 3'd0,
    KIND_HEADER   = 3'd1,
    KIND_BYTE     = 3'd2,
    KIND_CHECKSUM = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_BAD_CHECKSUM = 3'd1,
    ST_BAD_PRIORITY = 3'd2,
    ST_QUEUE_FULL   = 3'd3,
    ST_TOO_LONG     = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] stamp;
    logic [7:0]  dest;
    logic [7:0]  src;
    logic [7:0]  prio;
    logic [7:0]  len;
    logic [7:0]  data;
    logic [7:0]  hdr_xor;
    logic        dq_prio;
  } cmd_t;

  typedef struct packed {
    logic [31:0]      stamp;
    logic [7:0]       dest;
    logic [7:0]       src;
    logic             prio;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] rcv;
  } hdr_t;

  typedef struct packed {
    kind_e            kind;
    status_e          status;
    logic [31:0]      stamp;
    logic [7:0]       dest;
    logic [7:0]       src;
    logic             prio;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    logic             last;
  } res_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic q, input logic [PTR_W-1:0] p);
    slot_of = q ? (SLOT_W'(RING) + SLOT_W'(p)) : SLOT_W'(p);
  endfunction

  function automatic logic [PAY_AW-1:0] pay_base(input logic [SLOT_W-1:0] s);
    pay_base = PAY_AW'(s * MAX_PAYLOAD);
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == PTR_W'(QUEUE_DEPTH)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

/* sv/checksummed_two_priority_packet_queue.sv */
// top level of the two-priority packet queue with xor checksum
`timescale 1ns / 1ps
// A word is taken when start_i is high and busy_o is low. Header, payload and
// checksum words are each handled by the back end in its idle state; a dequeue
// gives a header result, one result per payload byte and a checksum result (one
// empty result for an empty queue), the payload memory streaming one byte per
// cycle behind a registered header read. A four-entry command queue keeps taking
// words while a dequeue streams, and busy_o rises only when it is full. Results
// are registered, each shown for exactly one cycle with valid_o high; they cannot
// be held off, and last_o marks the final result of a word.
module checksummed_two_priority_packet_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] arrival_time_i,
  input  logic [7:0]  dest_addr_i,
  input  logic [7:0]  src_addr_i,
  input  logic [7:0]  packet_priority_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        dequeue_priority_i,
  output logic        valid_o,
  output logic [2:0]  result_kind_o,
  output logic [2:0]  status_o,
  output logic [31:0] out_time_o,
  output logic [7:0]  out_dest_o,
  output logic [7:0]  out_src_o,
  output logic        out_priority_o,
  output logic [5:0]  out_length_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import cpq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic pop;
  res_t res;

  cpq_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .opcode_i           (opcode_i),
    .arrival_time_i     (arrival_time_i),
    .dest_addr_i        (dest_addr_i),
    .src_addr_i         (src_addr_i),
    .packet_priority_i  (packet_priority_i),
    .payload_length_i   (payload_length_i),
    .data_byte_i        (data_byte_i),
    .dequeue_priority_i (dequeue_priority_i),
    .pop_i              (pop),
    .cmd_valid_o        (cmd_valid),
    .cmd_o              (cmd)
  );

  cpq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .res_valid_o (valid_o),
    .res_o       (res)
  );

  assign result_kind_o  = res.kind;
  assign status_o       = res.status;
  assign out_time_o     = res.stamp;
  assign out_dest_o     = res.dest;
  assign out_src_o      = res.src;
  assign out_priority_o = res.prio;
  assign out_length_o   = res.len;
  assign out_byte_o     = res.data;
  assign last_o         = res.last;

endmodule

/* sv/cpq_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module cpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/cpq_front.sv */
// front end: takes input words, decodes them and queues commands for the back end
`timescale 1ns / 1ps
module cpq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    opcode_i,
  input  logic [31:0]   arrival_time_i,
  input  logic [7:0]    dest_addr_i,
  input  logic [7:0]    src_addr_i,
  input  logic [7:0]    packet_priority_i,
  input  logic [7:0]    payload_length_i,
  input  logic [7:0]    data_byte_i,
  input  logic          dequeue_priority_i,
  input  logic          pop_i,
  output logic          cmd_valid_o,
  output cpq_pkg::cmd_t cmd_o
);
  import cpq_pkg::*;

  cmd_t                fifo_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CMDQ_AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CW-1:0]  count_q, count_d;
  cmd_t                in_cmd;
  logic                push;
  logic                pop;

  always_comb begin
    in_cmd         = '0;
    in_cmd.op      = op_e'(opcode_i);
    in_cmd.stamp   = arrival_time_i;
    in_cmd.dest    = dest_addr_i;
    in_cmd.src     = src_addr_i;
    in_cmd.prio    = packet_priority_i;
    in_cmd.len     = payload_length_i;
    in_cmd.data    = data_byte_i;
    in_cmd.hdr_xor = dest_addr_i ^ src_addr_i ^ packet_priority_i ^ payload_length_i;
    in_cmd.dq_prio = dequeue_priority_i;
  end

  assign busy_o      = (count_q == CMDQ_CW'(CMDQ_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign push = start_i && !busy_o;
  assign pop  = pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + CMDQ_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + CMDQ_AW'(1) : rd_ptr_q;
    count_d  = count_q + CMDQ_CW'(push) - CMDQ_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* sv/cpq_back.sv */
// back end: packet reception, queue bookkeeping and dequeue streaming
`timescale 1ns / 1ps
module cpq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cpq_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          res_valid_o,
  output cpq_pkg::res_t res_o
);
  import cpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HDR  = 4'b0010,
    S_PAY  = 4'b0100,
    S_CS   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // packet under reception
  logic [31:0] p_stamp_q, p_stamp_d;
  logic [7:0]  p_dest_q, p_dest_d;
  logic [7:0]  p_src_q, p_src_d;
  logic [7:0]  p_prio_q, p_prio_d;
  logic [7:0]  p_len_q, p_len_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  rcv_q, rcv_d;

  logic [PTR_W-1:0]  head_q [2];
  logic [PTR_W-1:0]  head_d [2];
  logic [PTR_W-1:0]  tail_q [2];
  logic [PTR_W-1:0]  tail_d [2];
  logic [FILL_W-1:0] fill_q [2];
  logic [FILL_W-1:0] fill_d [2];

  // dequeue in progress
  logic              dq_q, dq_d;
  logic [LEN_W-1:0]  dq_len_q, dq_len_d;
  logic [LEN_W-1:0]  dq_rcv_q, dq_rcv_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic [PAY_AW-1:0] base_q, base_d;
  logic [7:0]        cs_q, cs_d;

  res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic              hdr_we;
  logic [SLOT_W-1:0] hdr_waddr;
  hdr_t              hdr_wdata;
  logic [SLOT_W-1:0] hdr_raddr;
  hdr_t              hdr_rdata;
  logic              pay_we;
  logic [PAY_AW-1:0] pay_waddr;
  logic [7:0]        pay_wdata;
  logic [PAY_AW-1:0] pay_raddr;
  logic [7:0]        pay_rdata;

  logic              pq;
  logic [SLOT_W-1:0] in_slot;
  logic [SLOT_W-1:0] dq_slot;
  logic [7:0]        pay_byte;

  cpq_ram #(.WIDTH($bits(hdr_t)), .DEPTH(SLOTS)) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (hdr_waddr),
    .wdata_i (hdr_wdata),
    .raddr_i (hdr_raddr),
    .rdata_o (hdr_rdata)
  );

  cpq_ram #(.WIDTH(8), .DEPTH(PAY_DEPTH)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  assign pq       = p_prio_q[0];
  assign in_slot  = slot_of(pq, tail_q[pq]);
  assign dq_slot  = slot_of(cmd_i.dq_prio, head_q[cmd_i.dq_prio]);
  assign pay_byte = (idx_q < dq_rcv_q) ? pay_rdata : 8'd0;
  assign pop_o    = (state_q == S_IDLE) && cmd_valid_i;

  always_comb begin
    state_d     = state_q;
    p_stamp_d   = p_stamp_q;
    p_dest_d    = p_dest_q;
    p_src_d     = p_src_q;
    p_prio_d    = p_prio_q;
    p_len_d     = p_len_q;
    xor_d       = xor_q;
    rcv_d       = rcv_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    dq_d        = dq_q;
    dq_len_d    = dq_len_q;
    dq_rcv_d    = dq_rcv_q;
    idx_d       = idx_q;
    base_d      = base_q;
    cs_d        = cs_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    hdr_we      = 1'b0;
    hdr_waddr   = in_slot;
    hdr_wdata   = '0;
    hdr_raddr   = dq_slot;
    pay_we      = 1'b0;
    pay_waddr   = pay_base(in_slot) + PAY_AW'(rcv_q);
    pay_wdata   = cmd_i.data;
    pay_raddr   = base_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_HEADER: begin
              p_stamp_d = cmd_i.stamp;
              p_dest_d  = cmd_i.dest;
              p_src_d   = cmd_i.src;
              p_prio_d  = cmd_i.prio;
              p_len_d   = cmd_i.len;
              xor_d     = cmd_i.hdr_xor;
              rcv_d     = '0;
            end
            OP_PAYLOAD: begin
              if (rcv_q < p_len_q) begin
                xor_d = xor_q ^ cmd_i.data;
                rcv_d = rcv_q + 8'd1;
                if ((rcv_q < 8'(MAX_PAYLOAD)) && (p_prio_q < 8'd2)) begin
                  pay_we = 1'b1;
                end
              end
            end
            OP_CHECKSUM: begin
              res_valid_d = 1'b1;
              res_d.kind  = KIND_STATUS;
              res_d.last  = 1'b1;
              if (xor_q != cmd_i.data) begin
                res_d.status = ST_BAD_CHECKSUM;
              end else if (p_prio_q > 8'd1) begin
                res_d.status = ST_BAD_PRIORITY;
              end else if (p_len_q > 8'(MAX_PAYLOAD)) begin
                res_d.status = ST_TOO_LONG;
              end else if (fill_q[pq] == FILL_W'(QUEUE_DEPTH)) begin
                res_d.status = ST_QUEUE_FULL;
              end else begin
                res_d.status    = ST_ACCEPTED;
                hdr_we          = 1'b1;
                hdr_wdata.stamp = p_stamp_q;
                hdr_wdata.dest  = p_dest_q;
                hdr_wdata.src   = p_src_q;
                hdr_wdata.prio  = pq;
                hdr_wdata.len   = p_len_q[LEN_W-1:0];
                hdr_wdata.rcv   = rcv_q[LEN_W-1:0];
                tail_d[pq]      = advance(tail_q[pq]);
                fill_d[pq]      = fill_q[pq] + FILL_W'(1);
              end
              p_stamp_d = '0;
              p_dest_d  = '0;
              p_src_d   = '0;
              p_prio_d  = '0;
              p_len_d   = '0;
              xor_d     = '0;
              rcv_d     = '0;
            end
            OP_DEQUEUE: begin
              if (fill_q[cmd_i.dq_prio] == '0) begin
                res_valid_d = 1'b1;
                res_d.kind  = KIND_EMPTY;
                res_d.last  = 1'b1;
              end else begin
                dq_d    = cmd_i.dq_prio;
                base_d  = pay_base(dq_slot);
                state_d = S_HDR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_HDR: begin
        res_valid_d = 1'b1;
        res_d.kind  = KIND_HEADER;
        res_d.stamp = hdr_rdata.stamp;
        res_d.dest  = hdr_rdata.dest;
        res_d.src   = hdr_rdata.src;
        res_d.prio  = hdr_rdata.prio;
        res_d.len   = hdr_rdata.len;
        dq_len_d    = hdr_rdata.len;
        dq_rcv_d    = hdr_rdata.rcv;
        cs_d        = hdr_rdata.dest ^ hdr_rdata.src ^ {7'd0, hdr_rdata.prio}
                    ^ {2'd0, hdr_rdata.len};
        idx_d       = '0;
        pay_raddr   = base_q;
        state_d     = (hdr_rdata.len != '0) ? S_PAY : S_CS;
      end
      S_PAY: begin
        res_valid_d = 1'b1;
        res_d.kind  = KIND_BYTE;
        res_d.data  = pay_byte;
        cs_d        = cs_q ^ pay_byte;
        idx_d       = idx_q + LEN_W'(1);
        pay_raddr   = base_q + PAY_AW'(idx_d);
        if (idx_d == dq_len_q) begin
          state_d = S_CS;
        end
      end
      S_CS: begin
        res_valid_d  = 1'b1;
        res_d.kind   = KIND_CHECKSUM;
        res_d.data   = cs_q;
        res_d.last   = 1'b1;
        head_d[dq_q] = advance(head_q[dq_q]);
        fill_d[dq_q] = fill_q[dq_q] - FILL_W'(1);
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    dq_q     <= dq_d;
    dq_len_q <= dq_len_d;
    dq_rcv_q <= dq_rcv_d;
    idx_q    <= idx_d;
    base_q   <= base_d;
    cs_q     <= cs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      p_stamp_q   <= '0;
      p_dest_q    <= '0;
      p_src_q     <= '0;
      p_prio_q    <= '0;
      p_len_q     <= '0;
      xor_q       <= '0;
      rcv_q       <= '0;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      fill_q      <= '{default: '0};
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_stamp_q   <= p_stamp_d;
      p_dest_q    <= p_dest_d;
      p_src_q     <= p_src_d;
      p_prio_q    <= p_prio_d;
      p_len_q     <= p_len_d;
      xor_q       <= xor_d;
      rcv_q       <= rcv_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* verif/checksummed_two_priority_packet_queue_tb.sv */
// self-checking testbench for the two-priority packet queue
`timescale 1ns / 1ps
module checksummed_two_priority_packet_queue_tb;
  import cpq_pkg::*;

  localparam int WORD_TARGET   = 410;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [31:0]              stamp;
    logic [7:0]               dest;
    logic [7:0]               src;
    logic [LEN_W-1:0]         len;
    logic [8*MAX_PAYLOAD-1:0] bytes;
  } held_pkt_t;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        start_i            = 1'b0;
  logic [1:0]  opcode_i           = OP_HEADER;
  logic [31:0] arrival_time_i     = '0;
  logic [7:0]  dest_addr_i        = '0;
  logic [7:0]  src_addr_i         = '0;
  logic [7:0]  packet_priority_i  = '0;
  logic [7:0]  payload_length_i   = '0;
  logic [7:0]  data_byte_i        = '0;
  logic        dequeue_priority_i = 1'b0;
  logic        busy_o;
  logic        valid_o;
  logic [2:0]  result_kind_o;
  logic [2:0]  status_o;
  logic [31:0] out_time_o;
  logic [7:0]  out_dest_o;
  logic [7:0]  out_src_o;
  logic        out_priority_o;
  logic [5:0]  out_length_o;
  logic [7:0]  out_byte_o;
  logic        last_o;

  // queue model state
  held_pkt_t                held_pkts[2][$];
  logic [31:0]              rx_stamp = '0;
  logic [7:0]               rx_dest  = '0;
  logic [7:0]               rx_src   = '0;
  logic [7:0]               rx_prio  = '0;
  logic [7:0]               rx_len   = '0;
  logic [7:0]               rx_xor   = '0;
  logic [7:0]               rx_count = '0;
  logic [8*MAX_PAYLOAD-1:0] rx_bytes = '0;

  res_t awaited[$];
  int   errors     = 0;
  int   words_sent = 0;
  int   burst_left = 0;
  bit   steady     = 1'b0;

  checksummed_two_priority_packet_queue uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .opcode_i           (opcode_i),
    .arrival_time_i     (arrival_time_i),
    .dest_addr_i        (dest_addr_i),
    .src_addr_i         (src_addr_i),
    .packet_priority_i  (packet_priority_i),
    .payload_length_i   (payload_length_i),
    .data_byte_i        (data_byte_i),
    .dequeue_priority_i (dequeue_priority_i),
    .valid_o            (valid_o),
    .result_kind_o      (result_kind_o),
    .status_o           (status_o),
    .out_time_o         (out_time_o),
    .out_dest_o         (out_dest_o),
    .out_src_o          (out_src_o),
    .out_priority_o     (out_priority_o),
    .out_length_o       (out_length_o),
    .out_byte_o         (out_byte_o),
    .last_o             (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic res_t make_result(input kind_e kind, input status_e st,
                                       input logic [31:0] stamp, input logic [7:0] dest,
                                       input logic [7:0] src, input logic prio,
                                       input logic [LEN_W-1:0] len, input logic [7:0] data,
                                       input logic last);
    res_t r;
    r.kind   = kind;
    r.status = st;
    r.stamp  = stamp;
    r.dest   = dest;
    r.src    = src;
    r.prio   = prio;
    r.len    = len;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  function automatic void clear_rx();
    rx_stamp = '0;
    rx_dest  = '0;
    rx_src   = '0;
    rx_prio  = '0;
    rx_len   = '0;
    rx_xor   = '0;
    rx_count = '0;
    rx_bytes = '0;
  endfunction

  // updates the queue model with one accepted word and queues the results it causes
  function automatic void advance_queue_model(input op_e op, input logic [31:0] stamp,
                                              input logic [7:0] dest, input logic [7:0] src,
                                              input logic [7:0] prio, input logic [7:0] len,
                                              input logic [7:0] data, input logic dq);
    held_pkt_t pkt;
    status_e   st;
    logic [7:0] sum;
    int i;
    case (op)
      OP_HEADER: begin
        clear_rx();
        rx_stamp = stamp;
        rx_dest  = dest;
        rx_src   = src;
        rx_prio  = prio;
        rx_len   = len;
        rx_xor   = dest ^ src ^ prio ^ len;
      end
      OP_PAYLOAD: begin
        if (rx_count < rx_len) begin
          rx_xor = rx_xor ^ data;
          if (rx_count < MAX_PAYLOAD) rx_bytes[rx_count*8 +: 8] = data;
          rx_count = rx_count + 8'd1;
        end
      end
      OP_CHECKSUM: begin
        if (rx_xor != data) begin
          st = ST_BAD_CHECKSUM;
        end else if (rx_prio > 1) begin
          st = ST_BAD_PRIORITY;
        end else if (rx_len > MAX_PAYLOAD) begin
          st = ST_TOO_LONG;
        end else if (held_pkts[rx_prio[0]].size() >= QUEUE_DEPTH) begin
          st = ST_QUEUE_FULL;
        end else begin
          pkt.stamp = rx_stamp;
          pkt.dest  = rx_dest;
          pkt.src   = rx_src;
          pkt.len   = rx_len[LEN_W-1:0];
          pkt.bytes = rx_bytes;
          held_pkts[rx_prio[0]].push_back(pkt);
          st = ST_ACCEPTED;
        end
        awaited.push_back(make_result(KIND_STATUS, st, '0, '0, '0, 1'b0, '0, '0, 1'b1));
        clear_rx();
      end
      default: begin
        if (held_pkts[dq].size() == 0) begin
          awaited.push_back(make_result(KIND_EMPTY, ST_ACCEPTED, '0, '0, '0, 1'b0, '0, '0,
                                        1'b1));
        end else begin
          pkt = held_pkts[dq].pop_front();
          sum = pkt.dest ^ pkt.src ^ {7'b0, dq} ^ {2'b0, pkt.len};
          awaited.push_back(make_result(KIND_HEADER, ST_ACCEPTED, pkt.stamp, pkt.dest,
                                        pkt.src, dq, pkt.len, '0, 1'b0));
          for (i = 0; i < pkt.len; i++) begin
            sum = sum ^ pkt.bytes[i*8 +: 8];
            awaited.push_back(make_result(KIND_BYTE, ST_ACCEPTED, '0, '0, '0, 1'b0, '0,
                                          pkt.bytes[i*8 +: 8], 1'b0));
          end
          awaited.push_back(make_result(KIND_CHECKSUM, ST_ACCEPTED, '0, '0, '0, 1'b0, '0,
                                        sum, 1'b1));
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && valid_o) begin
      if (awaited.size() == 0) begin
        $error("result_kind unexpected: expected none, got 0x%0h", result_kind_o);
        errors++;
      end else begin
        want = awaited.pop_front();
        check_field("result_kind", want.kind, result_kind_o);
        check_field("status", want.status, status_o);
        check_field("out_time", want.stamp, out_time_o);
        check_field("out_dest", want.dest, out_dest_o);
        check_field("out_src", want.src, out_src_o);
        check_field("out_priority", want.prio, out_priority_o);
        check_field("out_length", want.len, out_length_o);
        check_field("out_byte", want.data, out_byte_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  task automatic send_word(input op_e op, input logic [31:0] stamp, input logic [7:0] dest,
                           input logic [7:0] src, input logic [7:0] prio,
                           input logic [7:0] len, input logic [7:0] data, input logic dq);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i            <= 1'b1;
    opcode_i           <= op;
    arrival_time_i     <= stamp;
    dest_addr_i        <= dest;
    src_addr_i         <= src;
    packet_priority_i  <= prio;
    payload_length_i   <= len;
    data_byte_i        <= data;
    dequeue_priority_i <= dq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    advance_queue_model(op, stamp, dest, src, prio, len, data, dq);
    words_sent++;
  endtask

  task automatic send_header(input logic [31:0] stamp, input logic [7:0] dest,
                             input logic [7:0] src, input logic [7:0] prio,
                             input logic [7:0] len);
    send_word(OP_HEADER, stamp, dest, src, prio, len, 8'($urandom),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_byte_word(input op_e op, input logic [7:0] data);
    send_word(op, $urandom, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), data,
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_dequeue(input logic q);
    send_word(OP_DEQUEUE, $urandom, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), q);
  endtask

  // header, nbytes payload bytes, then the checksum; dq_pct mixes dequeues into the payload
  task automatic send_packet(input logic [31:0] stamp, input logic [7:0] dest,
                             input logic [7:0] src, input logic [7:0] prio,
                             input logic [7:0] len, input int nbytes, input bit bad_sum,
                             input int dq_pct);
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    sum = dest ^ src ^ prio ^ len;
    send_header(stamp, dest, src, prio, len);
    for (i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      if (i < len) sum = sum ^ b;
      send_byte_word(OP_PAYLOAD, b);
      if ($urandom_range(1, 100) <= dq_pct) send_dequeue(1'($urandom_range(0, 1)));
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte_word(OP_CHECKSUM, sum);
  endtask

  task automatic wait_all_results();
    start_i <= 1'b0;
    burst_left = 0;
    while (awaited.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_basic_flow();
    send_packet(32'h1234_5678, 8'h11, 8'h22, 8'd0, 8'd0, 0, 1'b0, 0);
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'd1, 8'd3, 3, 1'b0, 0);
    send_dequeue(1'b0);
    send_dequeue(1'b1);
    send_dequeue(1'b0);
    send_dequeue(1'b1);
  endtask

  task automatic test_field_extremes();
    send_packet(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'd1, 8'd2, 2, 1'b0, 0);
    send_packet(32'h0000_0000, 8'h00, 8'h00, 8'd0, 8'd1, 1, 1'b0, 0);
    send_dequeue(1'b1);
    send_dequeue(1'b0);
  endtask

  task automatic test_status_order();
    // bad checksum beats bad priority, bad priority beats too long
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'h80, 8'd1, 1, 1'b1, 0);
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'hFF, 8'hC8, 1, 1'b0, 0);
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'd2, 8'd0, 0, 1'b0, 0);
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'd0, 8'hFF, 2, 1'b0, 0);
  endtask

  task automatic test_framing();
    // stray payload and a checksum with no header form an empty priority 0 packet
    send_byte_word(OP_PAYLOAD, 8'hFF);
    send_byte_word(OP_CHECKSUM, 8'h00);
    // abandoned header, restarted by the next one
    send_header($urandom, 8'($urandom), 8'($urandom), 8'd1, 8'd3);
    send_byte_word(OP_PAYLOAD, 8'($urandom));
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'd1, 8'd2, 2, 1'b0, 0);
    // extra bytes, short payload, dequeues during reception
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'd0, 8'd2, 5, 1'b0, 0);
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'd1, 8'd4, 1, 1'b0, 100);
    wait_all_results();
    repeat (3) send_dequeue(1'b0);
    repeat (3) send_dequeue(1'b1);
  endtask

  task automatic test_queue_full();
    logic q;
    logic [7:0] len;
    q = 1'($urandom_range(0, 1));
    while (held_pkts[q].size() != 0) send_dequeue(q);
    repeat (QUEUE_DEPTH + 1) begin
      len = 8'($urandom_range(0, 2));
      send_packet($urandom, 8'($urandom), 8'($urandom), {7'b0, q}, len, len, 1'b0, 0);
    end
    // too long beats queue full
    send_packet($urandom, 8'($urandom), 8'($urandom), {7'b0, q}, 8'd70, 0, 1'b0, 0);
    send_packet($urandom, 8'($urandom), 8'($urandom), {7'b0, q}, 8'd1, 1, 1'b1, 0);
    repeat (QUEUE_DEPTH + 1) send_dequeue(q);
  endtask

  task automatic test_random_traffic();
    int n;
    int dq_pct;
    int action;
    int nbytes;
    logic [7:0] prio;
    logic [7:0] len;
    n = 0;
    dq_pct = 25;
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 1)), 8'd62, 62,
                1'b0, 3);
    send_packet($urandom, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 1)), 8'd63, 63,
                1'b0, 3);
    while (words_sent < WORD_TARGET) begin
      if (n % 30 == 0) begin
        dq_pct = $urandom_range(5, 50);
        steady = ($urandom_range(0, 4) == 0);
      end
      n++;
      action = $urandom_range(0, 99);
      if (action < dq_pct) begin
        send_dequeue(1'($urandom_range(0, 1)));
      end else if (action < 94) begin
        prio = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        len = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        nbytes = (len > 8) ? $urandom_range(0, 8) : len;
        if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, 11);
        send_packet($urandom, 8'($urandom), 8'($urandom), prio, len, nbytes,
                    $urandom_range(0, 6) == 0, 10);
      end else begin
        case ($urandom_range(0, 2))
          0: send_byte_word(OP_PAYLOAD, 8'($urandom));
          1: send_byte_word(OP_CHECKSUM, 8'($urandom));
          default: send_header($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom_range(0, 6)));
        endcase
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_flow();
    test_field_extremes();
    test_status_order();
    test_framing();
    test_queue_full();
    test_random_traffic();
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/cpq_pkg.sv
sv/cpq_ram.sv
sv/cpq_front.sv
sv/cpq_back.sv
sv/checksummed_two_priority_packet_queue.sv
verif/checksummed_two_priority_packet_queue_tb.sv
